/* sv/ostt_pkg.sv */
// Package for the one-shot timer table: request, result and slot record
// types, action and result codes. Used by ostt_front, ostt_back and one_shot_timer_table.
`default_nettype none
package ostt_pkg;

   localparam int MAX_RESULTS = 16;

   typedef enum logic [2:0] {
      ACT_ARM    = 3'd0,
      ACT_CANCEL = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_TICK   = 3'd3,
      ACT_STOP   = 3'd4
   } act_type;

   localparam logic [1:0] KIND_ARMED = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;

   typedef struct packed {
      act_type     action;
      logic [63:0] now_ms;
      logic [63:0] delay_ms;
      logic [31:0] user_tag;
      logic        with_notify;
      logic [31:0] timer_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] result_id;
      logic [31:0] fired_tag;
      logic [63:0] fired_timeout;
      logic [63:0] early_elapsed;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] tag;
      logic [63:0] start;
      logic [63:0] timeout;
   } slot_type;

endpackage
`default_nettype wire

/* sv/ostt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ostt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* sv/ostt_fifo.sv */
// Small register queue with push/full and pop/empty sides.
// No dependencies.
`default_nettype none
module ostt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         data_ff[wptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

/* sv/ostt_front.sv */
// Front end: accepts requests, drops unused action codes and queues the rest
// for the engine. Depends on ostt_pkg and ostt_fifo.
`default_nettype none
module ostt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [2:0]        action,
   input  wire logic [63:0]       now_ms,
   input  wire logic [63:0]       delay_ms,
   input  wire logic [31:0]       user_tag,
   input  wire logic              with_notify,
   input  wire logic [31:0]       timer_id,
   output logic                   q_valid,
   input  wire logic              q_pop,
   output ostt_pkg::req_type      q_req
);
   import ostt_pkg::*;

   req_type req;
   logic    known, q_empty;
   logic [$bits(req_type)-1:0] q_bits;

   always_comb begin
      case (action) inside
         [ACT_ARM:ACT_STOP]: known = 1'b1;
         default:            known = 1'b0;
      endcase
   end

   assign req.action      = act_type'(action);
   assign req.now_ms      = now_ms;
   assign req.delay_ms    = delay_ms;
   assign req.user_tag    = user_tag;
   assign req.with_notify = with_notify;
   assign req.timer_id    = timer_id;

   // Unknown codes are accepted and discarded here.
   ostt_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_q (
      .clock (clock),
      .reset (reset),
      .push  (push && known),
      .wdata (req),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_bits),
      .empty (q_empty)
   );

   assign q_valid = !q_empty;
   assign q_req   = req_type'(q_bits);
endmodule
`default_nettype wire

/* sv/ostt_back.sv */
// Engine: owns the slot table, arms timers, handles stop and walks the slots
// for cancel, remove and tick. Depends on ostt_pkg and ostt_ram.
`default_nettype none
module ostt_back #(
   parameter int SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire ostt_pkg::req_type q_req,
   output logic                   res_push,
   output ostt_pkg::rsp_type      res_data,
   input  wire logic              res_full
);
   import ostt_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int NW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [SLOTS-1:0] used_ff, used_in, notify_ff, notify_in;
   logic [SLOTS-1:0] canc_ff, canc_in, fired_ff, fired_in;
   logic [31:0]    next_id_ff, next_id_in;
   logic           running_ff, running_in;
   req_type        cur_ff, cur_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [NW-1:0]  n_ff, n_in;
   rsp_type        pend_ff, pend_in;
   logic           pend_v_ff, pend_v_in;

   logic           ram_we;
   logic [IW-1:0]  ram_raddr, free_idx;
   logic           have_free;
   slot_type       wslot, rslot;
   logic [$bits(slot_type)-1:0] rbits;
   logic [31:0]    nid;
   logic [63:0]    elapsed;
   logic           expired, fire, stall, at_end;

   always_comb begin
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            have_free = 1'b1;
            free_idx  = IW'(i);
         end
      end
   end

   assign nid            = (next_id_ff + 32'd1 == 32'd0) ? 32'd1 : next_id_ff + 32'd1;
   assign wslot.id       = nid;
   assign wslot.tag      = q_req.user_tag;
   assign wslot.start    = q_req.now_ms;
   assign wslot.timeout  = q_req.delay_ms;
   assign rslot          = slot_type'(rbits);
   assign elapsed        = cur_ff.now_ms - rslot.start;
   assign expired        = elapsed >= rslot.timeout;
   assign at_end         = (idx_ff == IW'(SLOTS - 1));

   ostt_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (free_idx),
      .wdata (wslot),
      .raddr (ram_raddr),
      .rdata (rbits)
   );

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      notify_in  = notify_ff;
      canc_in    = canc_ff;
      fired_in   = fired_ff;
      next_id_in = next_id_ff;
      running_in = running_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      pend_in    = pend_ff;
      pend_v_in  = pend_v_ff;
      q_pop      = 1'b0;
      res_push   = 1'b0;
      res_data   = pend_ff;
      ram_we     = 1'b0;
      ram_raddr  = '0;
      fire       = 1'b0;
      stall      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (!running_ff) begin
                  q_pop = 1'b1;
               end else begin
                  case (q_req.action)
                     ACT_ARM: begin
                        if (!res_full) begin
                           q_pop                  = 1'b1;
                           res_push               = 1'b1;
                           res_data               = '0;
                           res_data.last          = 1'b1;
                           if (have_free) begin
                              ram_we              = 1'b1;
                              next_id_in          = nid;
                              used_in[free_idx]   = 1'b1;
                              notify_in[free_idx] = q_req.with_notify;
                              canc_in[free_idx]   = 1'b0;
                              fired_in[free_idx]  = 1'b0;
                              res_data.kind       = KIND_ARMED;
                              res_data.result_id  = nid;
                           end else begin
                              res_data.kind       = KIND_FULL;
                           end
                        end
                     end
                     ACT_STOP: begin
                        q_pop      = 1'b1;
                        used_in    = '0;
                        running_in = 1'b0;
                     end
                     default: begin
                        q_pop     = 1'b1;
                        cur_in    = q_req;
                        idx_in    = '0;
                        n_in      = '0;
                        pend_v_in = 1'b0;
                        state_in  = ST_PRIME;
                     end
                  endcase
               end
            end
         end
         ST_PRIME: begin
            ram_raddr = '0;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (used_ff[idx_ff]) begin
               if (cur_ff.action == ACT_TICK) begin
                  if (fired_ff[idx_ff]) begin
                     used_in[idx_ff] = 1'b0;
                  end else if (expired || canc_ff[idx_ff]) begin
                     if (!notify_ff[idx_ff]) begin
                        used_in[idx_ff] = 1'b0;
                     end else if (n_ff < NW'(MAX_RESULTS)) begin
                        fire = 1'b1;
                     end
                  end
               end else if (rslot.id == cur_ff.timer_id) begin
                  canc_in[idx_ff] = 1'b1;
                  if (cur_ff.action == ACT_REMOVE) begin
                     notify_in[idx_ff] = 1'b0;
                  end
               end
            end
            // A held fire result can only leave once the result queue has room.
            stall = fire && pend_v_ff && res_full;
            if (stall) begin
               used_in   = used_ff;
               notify_in = notify_ff;
               canc_in   = canc_ff;
               ram_raddr = idx_ff;
            end else begin
               if (fire) begin
                  res_push              = pend_v_ff;
                  res_data.last         = 1'b0;
                  pend_v_in             = 1'b1;
                  pend_in.kind          = KIND_FIRED;
                  pend_in.result_id     = rslot.id;
                  pend_in.fired_tag     = rslot.tag;
                  pend_in.fired_timeout = rslot.timeout;
                  pend_in.early_elapsed = expired ? 64'd0 : elapsed;
                  pend_in.last          = 1'b0;
                  fired_in[idx_ff]      = 1'b1;
                  notify_in[idx_ff]     = 1'b0;
                  n_in                  = n_ff + 1'b1;
               end
               ram_raddr = idx_ff + 1'b1;
               idx_in    = idx_ff + 1'b1;
               if (at_end) begin
                  state_in = (cur_ff.action == ACT_TICK) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (!res_full) begin
               res_push      = 1'b1;
               res_data.last = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         next_id_ff <= '0;
         running_ff <= 1'b1;
         pend_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         next_id_ff <= next_id_in;
         running_ff <= running_in;
         pend_v_ff  <= pend_v_in;
      end
      notify_ff <= notify_in;
      canc_ff   <= canc_in;
      fired_ff  <= fired_in;
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      pend_ff   <= pend_in;
   end
endmodule
`default_nettype wire

/* sv/one_shot_timer_table.sv */
// One-shot timer table: arm, cancel, remove, tick and stop requests in, arm
// answers and fire notices out. Cancel and remove walk the slot RAM one slot
// per cycle; a tick walks it in the same way while the result queue has room
// and then flushes its last fire notice. A full result queue also holds back
// arm requests. A tick holds each fire notice back until the next one so that
// the last one can be flagged. After a stop request every later request is
// accepted and discarded.
// Depends on ostt_pkg, ostt_front, ostt_back and ostt_fifo.
`default_nettype none
module one_shot_timer_table #(
   parameter int SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_action,
   input  wire logic [63:0] req_now_ms,
   input  wire logic [63:0] req_delay_ms,
   input  wire logic [31:0] req_user_tag,
   input  wire logic        req_with_notify,
   input  wire logic [31:0] req_timer_id,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_result_id,
   output logic [31:0]      rsp_fired_tag,
   output logic [63:0]      rsp_fired_timeout,
   output logic [63:0]      rsp_early_elapsed,
   output logic             rsp_last
);
   import ostt_pkg::*;

   logic    q_valid, q_pop, res_push, res_full;
   req_type q_req;
   rsp_type res_data, rsp;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   ostt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .action      (req_action),
      .now_ms      (req_now_ms),
      .delay_ms    (req_delay_ms),
      .user_tag    (req_user_tag),
      .with_notify (req_with_notify),
      .timer_id    (req_timer_id),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_req       (q_req)
   );

   ostt_back #(.SLOTS(SLOTS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_req    (q_req),
      .res_push (res_push),
      .res_data (res_data),
      .res_full (res_full)
   );

   ostt_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (pop),
      .rdata (rsp_bits),
      .empty (empty)
   );

   assign rsp               = rsp_type'(rsp_bits);
   assign rsp_kind          = rsp.kind;
   assign rsp_result_id     = rsp.result_id;
   assign rsp_fired_tag     = rsp.fired_tag;
   assign rsp_fired_timeout = rsp.fired_timeout;
   assign rsp_early_elapsed = rsp.early_elapsed;
   assign rsp_last          = rsp.last;
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for one_shot_timer_table: a directed table, random
// arm/cancel/remove/tick traffic and closing stop requests, checked against a
// behavioral predictor. Depends on ostt_pkg and the one_shot_timer_table RTL.
`timescale 1ns / 1ps
module tb_top;
   import ostt_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCHDOG = 20000;

   typedef struct {
      logic [2:0]  action;
      logic [63:0] now_ms;
      logic [63:0] delay_ms;
      logic [31:0] user_tag;
      logic        with_notify;
      logic [31:0] timer_id;
      bit          has_fixed;
      rsp_type     fixed;
   } stim_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic        full, empty;
   logic [2:0]  req_action = '0;
   logic [63:0] req_now_ms = '0;
   logic [63:0] req_delay_ms = '0;
   logic [31:0] req_user_tag = '0;
   logic        req_with_notify = 1'b0;
   logic [31:0] req_timer_id = '0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_result_id, rsp_fired_tag;
   logic [63:0] rsp_fired_timeout, rsp_early_elapsed;
   logic        rsp_last;

   // Predictor state.
   bit          t_used[NSLOT];
   bit          t_notify[NSLOT];
   bit          t_cancel[NSLOT];
   bit          t_fired[NSLOT];
   slot_type    t_slot[NSLOT];
   logic [31:0] t_next_id;
   bit          t_running;

   rsp_type     pending_rsp[$];
   logic [31:0] live_ids[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          hold_pop = 0;
   logic [63:0] clock_ms = 64'd1000;

   always #5 clock = ~clock;

   one_shot_timer_table #(.SLOTS(NSLOT)) u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_action(req_action), .req_now_ms(req_now_ms),
      .req_delay_ms(req_delay_ms), .req_user_tag(req_user_tag),
      .req_with_notify(req_with_notify), .req_timer_id(req_timer_id),
      .empty(empty), .pop(pop), .rsp_kind(rsp_kind),
      .rsp_result_id(rsp_result_id), .rsp_fired_tag(rsp_fired_tag),
      .rsp_fired_timeout(rsp_fired_timeout),
      .rsp_early_elapsed(rsp_early_elapsed), .rsp_last(rsp_last)
   );

   function automatic rsp_type make_rsp(logic [1:0] k, logic [31:0] id,
                                        logic [31:0] tg, logic [63:0] tmo,
                                        logic [63:0] early, logic lst);
      rsp_type r;
      r.kind = k; r.result_id = id; r.fired_tag = tg;
      r.fired_timeout = tmo; r.early_elapsed = early; r.last = lst;
      return r;
   endfunction

   // Applies one request to the predictor and queues the results it causes.
   function automatic void predict_timers(stim_row s);
      int free_idx;
      int n;
      logic [63:0] elapsed;
      rsp_type fires[$];
      if (!t_running) return;
      case (s.action)
         ACT_ARM: begin
            free_idx = -1;
            for (int i = 0; i < NSLOT; i++)
               if (!t_used[i] && free_idx < 0) free_idx = i;
            if (free_idx < 0) begin
               pending_rsp.insert(pending_rsp.size(),
                                  make_rsp(KIND_FULL, 0, 0, 0, 0, 1'b1));
            end else begin
               t_next_id = t_next_id + 1;
               if (t_next_id == 0) t_next_id = 1;
               t_used[free_idx] = 1;
               t_slot[free_idx].id = t_next_id;
               t_slot[free_idx].tag = s.user_tag;
               t_slot[free_idx].start = s.now_ms;
               t_slot[free_idx].timeout = s.delay_ms;
               t_notify[free_idx] = s.with_notify;
               t_cancel[free_idx] = 0;
               t_fired[free_idx] = 0;
               live_ids.insert(live_ids.size(), t_next_id);
               pending_rsp.insert(pending_rsp.size(),
                                  make_rsp(KIND_ARMED, t_next_id, 0, 0, 0, 1'b1));
            end
         end
         ACT_CANCEL, ACT_REMOVE: begin
            for (int i = 0; i < NSLOT; i++)
               if (t_used[i] && t_slot[i].id == s.timer_id) begin
                  t_cancel[i] = 1;
                  if (s.action == ACT_REMOVE) t_notify[i] = 0;
               end
         end
         ACT_TICK: begin
            n = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (!t_used[i]) continue;
               if (t_fired[i]) begin
                  t_used[i] = 0;
                  continue;
               end
               elapsed = s.now_ms - t_slot[i].start;
               if (!(elapsed >= t_slot[i].timeout || t_cancel[i])) continue;
               if (!t_notify[i]) begin
                  t_used[i] = 0;
                  continue;
               end
               if (n >= MAX_RESULTS) continue;
               fires.insert(fires.size(), make_rsp(KIND_FIRED, t_slot[i].id,
                  t_slot[i].tag, t_slot[i].timeout,
                  elapsed >= t_slot[i].timeout ? 64'd0 : elapsed, 1'b0));
               t_fired[i] = 1;
               t_notify[i] = 0;
               n++;
            end
            if (n > 0) fires[n-1].last = 1'b1;
            foreach (fires[j]) pending_rsp.insert(pending_rsp.size(), fires[j]);
         end
         ACT_STOP: begin
            for (int i = 0; i < NSLOT; i++) t_used[i] = 0;
            t_running = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic stim_row make_row(logic [2:0] a, logic [63:0] nw,
                                        logic [63:0] tmo, logic [31:0] tg,
                                        logic nt, logic [31:0] id);
      stim_row s;
      s.action = a; s.now_ms = nw; s.delay_ms = tmo; s.user_tag = tg;
      s.with_notify = nt; s.timer_id = id; s.has_fixed = 0;
      s.fixed = '0;
      return s;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Drives one request and waits until it is accepted. Push stays high after
   // acceptance and is dropped only when a gap follows.
   task automatic send_request(stim_row s);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predict_timers(s);
      if (s.has_fixed && pending_rsp.size() > 0
          && pending_rsp[pending_rsp.size()-1] != s.fixed) begin
         $display("%0t: table row mismatch, expected %h actual predictor %h",
                  $time, s.fixed, pending_rsp[pending_rsp.size()-1]);
         errors++;
      end
      push <= 1'b1;
      req_action <= s.action;
      req_now_ms <= s.now_ms;
      req_delay_ms <= s.delay_ms;
      req_user_tag <= s.user_tag;
      req_with_notify <= s.with_notify;
      req_timer_id <= s.timer_id;
      do @(posedge clock); while (full);
   endtask

   function automatic stim_row random_row();
      int pick;
      logic [31:0] id;
      pick = $urandom_range(0, 99);
      id = (live_ids.size() > 0 && $urandom_range(0, 4) != 0)
           ? live_ids[$urandom_range(0, live_ids.size() - 1)] : $urandom();
      if (pick < 40)
         return make_row(ACT_ARM, clock_ms - $urandom_range(0, 20),
            ($urandom_range(0, 15) == 0) ? rand64() : 64'($urandom_range(0, 400)),
            $urandom(), $urandom_range(0, 3) != 0, $urandom());
      else if (pick < 55)
         return make_row(ACT_CANCEL, rand64(), rand64(), $urandom(), $urandom(), id);
      else if (pick < 65)
         return make_row(ACT_REMOVE, rand64(), rand64(), $urandom(), $urandom(), id);
      else begin
         clock_ms = clock_ms + $urandom_range(0, 150);
         return make_row(ACT_TICK, clock_ms, rand64(), $urandom(), $urandom(), id);
      end
   endfunction

   // Result side: random pops with short and long stalls.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_pop) begin
            pop <= 1'b0;
            @(posedge clock);
         end else begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
               pop <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time,
               make_rsp(rsp_kind, rsp_result_id, rsp_fired_tag, rsp_fired_timeout,
                        rsp_early_elapsed, rsp_last));
            errors++;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_kind !== e.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_kind);
               errors++;
            end
            if (rsp_result_id !== e.result_id) begin
               $display("%0t: result_id expected %h actual %h", $time,
                        e.result_id, rsp_result_id);
               errors++;
            end
            if (rsp_fired_tag !== e.fired_tag) begin
               $display("%0t: fired_tag expected %h actual %h", $time,
                        e.fired_tag, rsp_fired_tag);
               errors++;
            end
            if (rsp_fired_timeout !== e.fired_timeout) begin
               $display("%0t: fired_timeout expected %h actual %h", $time,
                        e.fired_timeout, rsp_fired_timeout);
               errors++;
            end
            if (rsp_early_elapsed !== e.early_elapsed) begin
               $display("%0t: early_elapsed expected %h actual %h", $time,
                        e.early_elapsed, rsp_early_elapsed);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last expected %b actual %b", $time, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row dir[$];
      stim_row s;
      for (int i = 0; i < NSLOT; i++) begin
         t_used[i] = 0; t_notify[i] = 0; t_cancel[i] = 0; t_fired[i] = 0;
         t_slot[i] = '0;
      end
      t_next_id = 0;
      t_running = 1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: first arm after reset gets id 1, then fill the table.
      s = make_row(ACT_ARM, 64'd0, 64'd0, 32'hFFFF_FFFF, 1'b1, 32'd0);
      s.has_fixed = 1; s.fixed = make_rsp(KIND_ARMED, 32'd1, 0, 0, 0, 1'b1);
      dir.insert(dir.size(), s);
      s = make_row(ACT_ARM, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'd0, 1'b1, 32'hFFFF_FFFF);
      s.has_fixed = 1; s.fixed = make_rsp(KIND_ARMED, 32'd2, 0, 0, 0, 1'b1);
      dir.insert(dir.size(), s);
      for (int i = 0; i < NSLOT - 2; i++)
         dir.insert(dir.size(), make_row(ACT_ARM, 64'd5, 64'd100 + i, 32'hA000 + i,
                                         i % 3 != 0, 32'd0));
      s = make_row(ACT_ARM, 64'd5, 64'd5, 32'd5, 1'b1, 32'd0);
      s.has_fixed = 1; s.fixed = make_rsp(KIND_FULL, 0, 0, 0, 0, 1'b1);
      dir.insert(dir.size(), s);
      dir.insert(dir.size(), make_row(ACT_CANCEL, 0, 0, 0, 0, 32'd4));
      dir.insert(dir.size(), make_row(ACT_REMOVE, 0, 0, 0, 0, 32'd5));
      dir.insert(dir.size(), make_row(ACT_CANCEL, 0, 0, 0, 0, 32'h7777_0000));
      dir.insert(dir.size(), make_row(3'd5, 0, 0, 0, 1, 32'd3));
      dir.insert(dir.size(), make_row(3'd7, 0, 0, 0, 1, 32'd3));
      // Wrapped time: elapsed from the max start is small.
      dir.insert(dir.size(), make_row(ACT_TICK, 64'd50, 0, 0, 0, 0));
      dir.insert(dir.size(), make_row(ACT_TICK, 64'd200, 0, 0, 0, 0));
      foreach (dir[i]) send_request(dir[i]);

      // Random traffic, with one long hold-off on the result side.
      for (int k = 0; k < 200; k++) begin
         if (k == 60) begin
            fork
               begin
                  hold_pop = 1;
                  repeat (600) @(posedge clock);
                  hold_pop = 0;
               end
            join_none
         end
         // Once, arm the whole table and tick far ahead for a burst of fires.
         if (k == 120) begin
            for (int i = 0; i < NSLOT + 1; i++)
               send_request(make_row(ACT_ARM, clock_ms, 64'd1, $urandom(), 1'b1, 0));
            clock_ms = clock_ms + 10;
            send_request(make_row(ACT_TICK, clock_ms, 0, 0, 0, 0));
         end
         send_request(random_row());
      end
      send_request(make_row(ACT_STOP, rand64(), rand64(), $urandom(), 1, $urandom()));
      send_request(make_row(ACT_ARM, 0, 0, 0, 1, 0));
      send_request(make_row(ACT_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0));
      send_request(make_row(ACT_STOP, 0, 0, 0, 0, 0));
      push <= 1'b0;

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
